FILE: sv/lfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_START_MARKER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LENGTH   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH   = 2'd2;

  localparam logic [7:0]  MARKER_RESET  = 8'hAA;
  localparam logic [15:0] MIN_LEN_RESET = 16'd4;
  localparam logic [15:0] MAX_LEN_RESET = 16'd16384;
  localparam logic [15:0] HEADER_BYTES  = 16'd4;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_CMD    = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [15:0] min_len;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  sub_command;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        last_byte;
    logic        empty_frame;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   rx_byte_i
// output    out        out_valid_o/out_stall_i sub_command_o, payload_byte_o,
//                                              payload_length_o, last_byte_o, empty_frame_o
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One byte beat is accepted every cycle unless in_stall_o is raised; a result passes the input
// register, the combinational parser step and then the output register (or the skid stage).
// A skid stage behind the output register holds one result, so input beats keep flowing when the output first stalls.
// Reset returns the parser to the marker hunt and restores the register defaults.

module length_prefixed_frame_parser (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [lfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [15:0]                  cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [7:0]                   rx_byte_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [7:0]                   sub_command_o,
  output logic [7:0]                   payload_byte_o,
  output logic [15:0]                  payload_length_o,
  output logic                         last_byte_o,
  output logic                         empty_frame_o
);

  lfp_pkg::cfg_t cfg_q;
  lfp_pkg::res_t res;
  lfp_pkg::res_t out;
  logic          push;
  logic          room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= lfp_pkg::MARKER_RESET;
      cfg_q.min_len      <= lfp_pkg::MIN_LEN_RESET;
      cfg_q.max_len      <= lfp_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfp_pkg::CFG_START_MARKER: cfg_q.start_marker <= cfg_data_i[7:0];
        lfp_pkg::CFG_MIN_LENGTH:   cfg_q.min_len      <= cfg_data_i;
        lfp_pkg::CFG_MAX_LENGTH:   cfg_q.max_len      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .room_i     (room),
    .push_o     (push),
    .res_o      (res)
  );

  lfp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign sub_command_o    = out.sub_command;
  assign payload_byte_o   = out.payload_byte;
  assign payload_length_o = out.payload_length;
  assign last_byte_o      = out.last_byte;
  assign empty_frame_o    = out.empty_frame;

  // An empty frame never carries a payload byte or length.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |-> payload_byte_o == 8'd0 && payload_length_o == 16'd0)
    else $error("empty frame beat carries payload");

endmodule

`default_nettype wire

FILE: sv/lfp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire lfp_pkg::cfg_t cfg_i,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire  [7:0]       rx_byte_i,
  input  wire              room_i,
  output logic             push_o,
  output lfp_pkg::res_t    res_o
);

  logic            in_vld_q, in_vld_d;
  logic [7:0]      in_byte_q;
  logic            adv;
  logic            take;

  lfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     seen_q, seen_d;

  logic [15:0]     new_len;
  logic [15:0]     seen_inc;

  assign adv        = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign take       = in_valid_i && !in_stall_o;
  assign in_vld_d   = take || (in_vld_q && !adv);

  assign new_len  = {in_byte_q, len_q[7:0]};
  assign seen_inc = seen_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    seen_d  = seen_q;
    push_o  = 1'b0;
    res_o   = '0;
    if (adv) begin
      case (phase_q)
        lfp_pkg::PH_HUNT: begin
          if (in_byte_q == cfg_i.start_marker) begin
            seen_d  = 16'd1;
            phase_d = lfp_pkg::PH_CMD;
          end
        end
        lfp_pkg::PH_CMD: begin
          cmd_d   = in_byte_q;
          seen_d  = 16'd2;
          phase_d = lfp_pkg::PH_LEN_LO;
        end
        lfp_pkg::PH_LEN_LO: begin
          len_d   = {8'd0, in_byte_q};
          seen_d  = 16'd3;
          phase_d = lfp_pkg::PH_LEN_HI;
        end
        lfp_pkg::PH_LEN_HI: begin
          len_d   = new_len;
          seen_d  = 16'd4;
          phase_d = lfp_pkg::PH_DATA;
          if (new_len < lfp_pkg::HEADER_BYTES || new_len < cfg_i.min_len ||
              new_len > cfg_i.max_len) begin
            phase_d = lfp_pkg::PH_HUNT;
            cmd_d   = '0;
            len_d   = '0;
            seen_d  = '0;
          end else if (new_len == lfp_pkg::HEADER_BYTES) begin
            push_o            = 1'b1;
            res_o.sub_command = cmd_q;
            res_o.last_byte   = 1'b1;
            res_o.empty_frame = 1'b1;
            phase_d = lfp_pkg::PH_HUNT;
            cmd_d   = '0;
            len_d   = '0;
            seen_d  = '0;
          end
        end
        lfp_pkg::PH_DATA: begin
          push_o               = 1'b1;
          res_o.sub_command    = cmd_q;
          res_o.payload_byte   = in_byte_q;
          res_o.payload_length = len_q - lfp_pkg::HEADER_BYTES;
          seen_d               = seen_inc;
          if (seen_inc >= len_q) begin
            res_o.last_byte = 1'b1;
            phase_d = lfp_pkg::PH_HUNT;
            cmd_d   = '0;
            len_d   = '0;
            seen_d  = '0;
          end
        end
        default: begin
          phase_d = lfp_pkg::PH_HUNT;
          cmd_d   = '0;
          len_d   = '0;
          seen_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= lfp_pkg::PH_HUNT;
      cmd_q    <= '0;
      len_q    <= '0;
      seen_q   <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // A frame in its payload phase is always longer than its header and not yet complete.
  a_data_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == lfp_pkg::PH_DATA |-> (len_q > lfp_pkg::HEADER_BYTES && seen_q < len_q))
    else $error("payload phase with inconsistent frame length");

  // The end of a frame always returns the parser to the hunt.
  a_last_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.last_byte |=> phase_q == lfp_pkg::PH_HUNT)
    else $error("last beat did not return to hunt");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.empty_frame |-> res_o.last_byte && phase_q == lfp_pkg::PH_LEN_HI)
    else $error("empty frame beat not marked last");

endmodule

`default_nettype wire

FILE: sv/lfp_out.sv
`timescale 1ns / 1ps
`default_nettype none

module lfp_out (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire lfp_pkg::res_t res_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output lfp_pkg::res_t    out_o
);

  logic          out_vld_q, out_vld_d;
  logic          skid_vld_q, skid_vld_d;
  lfp_pkg::res_t out_q, out_d;
  lfp_pkg::res_t skid_q, skid_d;
  logic          free;

  assign free   = !out_vld_q || !out_stall_i;
  assign room_o = !skid_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (free) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = push_i;
        skid_d     = res_i;
      end else begin
        out_vld_d = push_i;
        out_d     = res_i;
      end
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // The skid stage only fills behind a held output beat.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid stage holds a beat ahead of the output register");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && out_stall_i |-> !push_i)
    else $error("result pushed into a full output stage");

endmodule

`default_nettype wire
